@@ rtl/spc_pkg.sv @@
// spc_pkg: shared types and constants for the superpixel cluster pass unit
// no dependencies; used by spc_dist_unit, spc_divider users and the top level
`timescale 1ns / 1ps

package spc_pkg;

  // fixed field widths
  localparam int CHAN_BITS     = 8;
  localparam int SLOT_BITS     = 6;
  localparam int COUNT_BITS    = 21;
  localparam int IN_COORD_BITS = 10;
  localparam int CFG_BITS      = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int USE_BITS      = 7;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_STEP      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOUR_WEIGHT  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTERS_IN_USE = 2'd2;

  // configuration reset values
  localparam logic [7:0]          GRID_STEP_RST      = 8'd16;
  localparam logic [7:0]          COLOUR_WEIGHT_RST  = 8'd10;
  localparam logic [USE_BITS-1:0] CENTERS_IN_USE_RST = 7'd64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // distance unit steps
  typedef logic [3:0] step_t;

  localparam step_t STEP_SQ_L  = 4'd0;
  localparam step_t STEP_SQ_A  = 4'd1;
  localparam step_t STEP_SQ_B  = 4'd2;
  localparam step_t STEP_SQ_X  = 4'd3;
  localparam step_t STEP_SQ_Y  = 4'd4;
  localparam step_t STEP_SC_C0 = 4'd5;
  localparam step_t STEP_SC_C1 = 4'd6;
  localparam step_t STEP_SC_S0 = 4'd7;
  localparam step_t STEP_SC_S1 = 4'd8;
  localparam step_t STEP_LAST  = STEP_SC_S1;

  typedef struct packed {
    logic  en;
    step_t step;
  } dist_ctrl_t;

endpackage

@@ rtl/spc_divider.sv @@
// spc_divider: restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps

module spc_divider #(
  parameter int NW  = 35,
  parameter int DVW = 21
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [NW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [NW-1:0]  quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_r;
  logic [DVW-1:0]  rem_r;
  logic [DVW-1:0]  dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [DVW:0]    rem_sh;
  logic            ge;
  logic [DVW:0]    rem_sub;

  // one trial subtraction per cycle
  always_comb begin
    rem_sh  = {rem_r, quo_r[NW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/spc_dist_unit.sv @@
// spc_dist_unit: window test and distance with one shared multiplier
// depends on spc_pkg for the step codes and control struct
`timescale 1ns / 1ps

module spc_dist_unit #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 4,
  localparam int CW  = spc_pkg::CHAN_BITS + FRAC_BITS,
  localparam int PW  = COORD_BITS + FRAC_BITS,
  localparam int DF  = (CW > PW) ? CW : PW,
  localparam int SQW = 2 * DF + 2,
  localparam int ACW = SQW + 16,
  localparam int DW  = ACW + 1
) (
  input  logic                                clk,
  input  spc_pkg::dist_ctrl_t                 ctrl,
  input  logic [COORD_BITS-1:0]               pix_x,
  input  logic [COORD_BITS-1:0]               pix_y,
  input  logic [3*spc_pkg::CHAN_BITS-1:0]     pix_col,
  input  logic [3*CW-1:0]                     cen_col,
  input  logic [2*PW-1:0]                     cen_pos,
  input  logic [7:0]                          grid_step,
  input  logic [7:0]                          colour_weight,
  output logic                                win_ok,
  output logic [DW-1:0]                       dist_val
);

  localparam int MA = SQW + 8;
  localparam int LW = ((COORD_BITS > 8) ? COORD_BITS : 8) + 1;
  localparam int HW = LW + FRAC_BITS;

  logic [ACW-1:0]   acc_c_r;
  logic [ACW-1:0]   acc_s_r;
  logic [MA-1:0]    mul_a;
  logic [DF-1:0]    mul_b;
  logic [MA+DF-1:0] prod;
  logic [ACW-1:0]   prod_t;
  logic [DF-1:0]    diff;

  function automatic logic win_axis(input logic [COORD_BITS-1:0] p,
                                    input logic [PW-1:0] c,
                                    input logic [7:0] s);
    logic lo_ok;
    logic hi_ok;
    lo_ok = (LW'(p) + LW'(s)) >= LW'(c >> FRAC_BITS);
    hi_ok = (HW'(p) << FRAC_BITS) < (HW'(c) + (HW'(s) << FRAC_BITS));
    return lo_ok && hi_ok;
  endfunction

  function automatic logic [DF-1:0] abs_diff(input logic [DF-1:0] a, input logic [DF-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // search window on both axes
  assign win_ok = win_axis(pix_x, cen_pos[PW-1:0], grid_step) &&
                  win_axis(pix_y, cen_pos[2*PW-1:PW], grid_step);

  // operand selection for the shared multiplier
  always_comb begin
    diff  = '0;
    mul_a = '0;
    mul_b = '0;
    case (ctrl.step)
      spc_pkg::STEP_SQ_L, spc_pkg::STEP_SQ_A, spc_pkg::STEP_SQ_B: begin
        diff = abs_diff(DF'(CW'(pix_col[ctrl.step[1:0]*spc_pkg::CHAN_BITS +:
                                        spc_pkg::CHAN_BITS]) << FRAC_BITS),
                        DF'(cen_col[ctrl.step[1:0]*CW +: CW]));
        mul_a = MA'(diff);
        mul_b = diff;
      end
      spc_pkg::STEP_SQ_X: begin
        diff  = abs_diff(DF'(PW'(pix_x) << FRAC_BITS), DF'(cen_pos[PW-1:0]));
        mul_a = MA'(diff);
        mul_b = diff;
      end
      spc_pkg::STEP_SQ_Y: begin
        diff  = abs_diff(DF'(PW'(pix_y) << FRAC_BITS), DF'(cen_pos[2*PW-1:PW]));
        mul_a = MA'(diff);
        mul_b = diff;
      end
      spc_pkg::STEP_SC_C0, spc_pkg::STEP_SC_C1: begin
        mul_a = acc_c_r[MA-1:0];
        mul_b = DF'(grid_step);
      end
      spc_pkg::STEP_SC_S0, spc_pkg::STEP_SC_S1: begin
        mul_a = acc_s_r[MA-1:0];
        mul_b = DF'(colour_weight);
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod   = mul_a * mul_b;
    prod_t = prod[ACW-1:0];
  end

  // colour and spatial accumulators
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      case (ctrl.step)
        spc_pkg::STEP_SQ_L:                         acc_c_r <= prod_t;
        spc_pkg::STEP_SQ_A, spc_pkg::STEP_SQ_B:     acc_c_r <= acc_c_r + prod_t;
        spc_pkg::STEP_SQ_X:                         acc_s_r <= prod_t;
        spc_pkg::STEP_SQ_Y:                         acc_s_r <= acc_s_r + prod_t;
        spc_pkg::STEP_SC_C0, spc_pkg::STEP_SC_C1:   acc_c_r <= prod_t;
        spc_pkg::STEP_SC_S0, spc_pkg::STEP_SC_S1:   acc_s_r <= prod_t;
        default: begin
          acc_c_r <= acc_c_r;
        end
      endcase
    end
  end

  assign dist_val = DW'(acc_c_r) + DW'(acc_s_r);

endmodule

@@ rtl/superpixel_cluster_pass_unit.sv @@
// superpixel_cluster_pass_unit: one clustering pass per scan, sequencer and stores
// depends on spc_pkg, spc_dist_unit and spc_divider
`timescale 1ns / 1ps

// A load transaction is written to the stores straight from idle. A pixel
// transaction walks the first centers_in_use slots one at a time through a
// single shared multiplier: a slot that is not live or whose window misses
// the pixel gets only the read and window test, a covered slot gets read,
// window test, five squares, four weight products and compare; then the
// winning slot's sums are updated, if one was found, and the result is
// presented. The end-of-pass pixel then sweeps every slot (read, check,
// write) and a live, non-empty slot adds five divisions through a
// one-bit-per-cycle divider. Input stall is high whenever the sequencer is
// not idle.
module superpixel_cluster_pass_unit #(
  parameter int MAX_CENTERS = 64,
  parameter int COORD_BITS  = 10,
  parameter int FRAC_BITS   = 4
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // input channel
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic                                    in_action,
  input  logic [spc_pkg::SLOT_BITS-1:0]           in_center_index,
  input  logic [spc_pkg::IN_COORD_BITS-1:0]       in_pos_x,
  input  logic [spc_pkg::IN_COORD_BITS-1:0]       in_pos_y,
  input  logic [spc_pkg::CHAN_BITS-1:0]           in_chan_l,
  input  logic [spc_pkg::CHAN_BITS-1:0]           in_chan_a,
  input  logic [spc_pkg::CHAN_BITS-1:0]           in_chan_b,
  input  logic                                    in_end_of_pass,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [spc_pkg::SLOT_BITS-1:0]           out_label,
  output logic                                    out_assigned,
  output logic                                    out_pass_done,
  // configuration port
  input  logic                                    cfg_wr_en,
  input  logic [spc_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [spc_pkg::CFG_BITS-1:0]            cfg_data
);

  localparam int NSLOT = (MAX_CENTERS < (2 ** spc_pkg::SLOT_BITS)) ?
                         MAX_CENTERS : (2 ** spc_pkg::SLOT_BITS);
  localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int CB    = spc_pkg::CHAN_BITS;
  localparam int NB    = spc_pkg::COUNT_BITS;
  localparam int CW    = CB + FRAC_BITS;
  localparam int PW    = COORD_BITS + FRAC_BITS;
  localparam int DF    = (CW > PW) ? CW : PW;
  localparam int SQW   = 2 * DF + 2;
  localparam int DW    = SQW + 17;
  localparam int CSW   = CB + NB;
  localparam int PSW   = COORD_BITS + NB;
  localparam int NW    = ((PSW > CSW) ? PSW : CSW) + FRAC_BITS;
  localparam int WALKW = 11;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD      = 4'd1;
  localparam logic [3:0] S_WIN     = 4'd2;
  localparam logic [3:0] S_CALC    = 4'd3;
  localparam logic [3:0] S_CMP     = 4'd4;
  localparam logic [3:0] S_UPD_RD  = 4'd5;
  localparam logic [3:0] S_UPD_WR  = 4'd6;
  localparam logic [3:0] S_OUT     = 4'd7;
  localparam logic [3:0] S_FIN_RD  = 4'd8;
  localparam logic [3:0] S_FIN_CHK = 4'd9;
  localparam logic [3:0] S_FIN_GO  = 4'd10;
  localparam logic [3:0] S_FIN_DIV = 4'd11;
  localparam logic [3:0] S_FIN_WR  = 4'd12;

  // division order over the five center fields
  localparam logic [2:0] K_LAST = 3'd4;

  // control registers
  logic [3:0]                     state_r, state_nxt;
  logic [IW-1:0]                  idx_r, idx_nxt;
  spc_pkg::step_t                 step_r, step_nxt;
  logic [IW-1:0]                  best_r, best_nxt;
  logic                           found_r, found_nxt;
  logic [2:0]                     div_k_r, div_k_nxt;
  logic                           fin_upd_r, fin_upd_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [NSLOT-1:0]               live_r;
  logic [7:0]                     grid_step_r;
  logic [7:0]                     colour_weight_r;
  logic [spc_pkg::USE_BITS-1:0]   centers_r;

  // payload registers
  logic [DW-1:0]                  best_d_r, best_d_nxt;
  logic [COORD_BITS-1:0]          px_r;
  logic [COORD_BITS-1:0]          py_r;
  logic [3*CB-1:0]                col_r;
  logic                           eop_r;
  logic [3*CW-1:0]                cq_r;
  logic [2*PW-1:0]                pq_r;
  logic [spc_pkg::SLOT_BITS-1:0]  out_label_r;
  logic                           out_assigned_r;
  logic                           out_pass_done_r;

  // stores and their registered read data
  logic [3*CW-1:0]                ccol_mem [NSLOT];
  logic [2*PW-1:0]                cpos_mem [NSLOT];
  logic [3*CSW-1:0]               csum_mem [NSLOT];
  logic [2*PSW-1:0]               psum_mem [NSLOT];
  logic [NB-1:0]                  cnt_mem  [NSLOT];
  logic [3*CW-1:0]                ccol_q;
  logic [2*PW-1:0]                cpos_q;
  logic [3*CSW-1:0]               csum_q;
  logic [2*PSW-1:0]               psum_q;
  logic [NB-1:0]                  cnt_q;

  // store write ports
  logic                           cm_we;
  logic [IW-1:0]                  cm_addr;
  logic [3*CW-1:0]                cm_col;
  logic [2*PW-1:0]                cm_pos;
  logic                           am_we;
  logic [IW-1:0]                  am_addr;
  logic [3*CSW-1:0]               am_csum;
  logic [2*PSW-1:0]               am_psum;
  logic [NB-1:0]                  am_cnt;

  logic                           in_accept;
  logic                           load_ok;
  logic                           out_load;
  logic [WALKW-1:0]               walk_n;
  logic                           last_slot;
  logic                           live_clr;
  spc_pkg::dist_ctrl_t            dctrl;
  logic                           win_ok;
  logic [DW-1:0]                  dist_val;
  logic                           div_start;
  logic                           div_done;
  logic [NW-1:0]                  div_dividend;
  logic [NW-1:0]                  div_quotient;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = in_accept && (in_action == spc_pkg::ACT_LOAD) &&
                     (WALKW'(in_center_index) < WALKW'(NSLOT));
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign walk_n    = (WALKW'(centers_r) > WALKW'(NSLOT)) ? WALKW'(NSLOT) : WALKW'(centers_r);
  assign last_slot = (WALKW'(idx_r) + WALKW'(1)) >= walk_n;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_step_r     <= spc_pkg::GRID_STEP_RST;
      colour_weight_r <= spc_pkg::COLOUR_WEIGHT_RST;
      centers_r       <= spc_pkg::CENTERS_IN_USE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        spc_pkg::CFG_GRID_STEP:      grid_step_r     <= cfg_data;
        spc_pkg::CFG_COLOUR_WEIGHT:  colour_weight_r <= cfg_data;
        spc_pkg::CFG_CENTERS_IN_USE: centers_r       <= cfg_data[spc_pkg::USE_BITS-1:0];
        default: begin
          centers_r <= centers_r;
        end
      endcase
    end
  end

  // shared distance unit
  assign dctrl.en   = (state_r == S_CALC);
  assign dctrl.step = step_r;

  spc_dist_unit #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dist (
    .clk           (clk),
    .ctrl          (dctrl),
    .pix_x         (px_r),
    .pix_y         (py_r),
    .pix_col       (col_r),
    .cen_col       (ccol_q),
    .cen_pos       (cpos_q),
    .grid_step     (grid_step_r),
    .colour_weight (colour_weight_r),
    .win_ok        (win_ok),
    .dist_val      (dist_val)
  );

  // dividend for the field under division
  always_comb begin
    case (div_k_r)
      3'd0, 3'd1, 3'd2:
        div_dividend = NW'(csum_q[div_k_r[1:0]*CSW +: CSW]) << FRAC_BITS;
      3'd3:    div_dividend = NW'(psum_q[PSW-1:0]) << FRAC_BITS;
      3'd4:    div_dividend = NW'(psum_q[2*PSW-1:PSW]) << FRAC_BITS;
      default: div_dividend = '0;
    endcase
  end

  assign div_start = (state_r == S_FIN_GO);

  spc_divider #(
    .NW  (NW),
    .DVW (NB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cnt_q),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    found_nxt     = found_r;
    div_k_nxt     = div_k_r;
    fin_upd_nxt   = fin_upd_r;
    live_clr      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept && (in_action == spc_pkg::ACT_PIXEL)) begin
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = (walk_n == '0) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_WIN;
      end
      S_WIN, S_CMP: begin
        if (state_r == S_WIN && live_r[idx_r] && win_ok) begin
          step_nxt  = spc_pkg::STEP_SQ_L;
          state_nxt = S_CALC;
        end else begin
          if (state_r == S_CMP && (!found_r || dist_val < best_d_r)) begin
            found_nxt  = 1'b1;
            best_nxt   = idx_r;
            best_d_nxt = dist_val;
          end
          if (last_slot) begin
            idx_nxt   = best_nxt;
            state_nxt = found_nxt ? S_UPD_RD : S_OUT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_RD;
          end
        end
      end
      S_CALC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == spc_pkg::STEP_LAST) begin
          state_nxt = S_CMP;
        end
      end
      S_UPD_RD: begin
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          idx_nxt   = '0;
          state_nxt = eop_r ? S_FIN_RD : S_IDLE;
        end
      end
      S_FIN_RD: begin
        state_nxt = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        div_k_nxt   = '0;
        fin_upd_nxt = live_r[idx_r] && (cnt_q != '0);
        live_clr    = live_r[idx_r] && (cnt_q == '0);
        state_nxt   = fin_upd_nxt ? S_FIN_GO : S_FIN_WR;
      end
      S_FIN_GO: begin
        state_nxt = S_FIN_DIV;
      end
      S_FIN_DIV: begin
        if (div_done) begin
          div_k_nxt = div_k_r + 1'b1;
          state_nxt = (div_k_r == K_LAST) ? S_FIN_WR : S_FIN_GO;
        end
      end
      S_FIN_WR: begin
        if (idx_r == IW'(NSLOT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_FIN_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      step_r      <= spc_pkg::STEP_SQ_L;
      best_r      <= '0;
      found_r     <= 1'b0;
      div_k_r     <= '0;
      fin_upd_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      step_r      <= step_nxt;
      best_r      <= best_nxt;
      found_r     <= found_nxt;
      div_k_r     <= div_k_nxt;
      fin_upd_r   <= fin_upd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // live bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
    end else begin
      if (load_ok) begin
        live_r[in_center_index[IW-1:0]] <= 1'b1;
      end
      if (live_clr) begin
        live_r[idx_r] <= 1'b0;
      end
    end
  end

  // pixel capture, best distance, quotients and result register
  always_ff @(posedge clk) begin
    best_d_r <= best_d_nxt;
    if (in_accept) begin
      px_r  <= COORD_BITS'(in_pos_x);
      py_r  <= COORD_BITS'(in_pos_y);
      col_r <= {in_chan_b, in_chan_a, in_chan_l};
      eop_r <= in_end_of_pass;
    end
    if (state_r == S_FIN_DIV && div_done) begin
      case (div_k_r)
        3'd0, 3'd1, 3'd2: cq_r[div_k_r[1:0]*CW +: CW] <= div_quotient[CW-1:0];
        3'd3:             pq_r[PW-1:0]                <= div_quotient[PW-1:0];
        3'd4:             pq_r[2*PW-1:PW]             <= div_quotient[PW-1:0];
        default: begin
          cq_r <= cq_r;
        end
      endcase
    end
    if (out_load) begin
      out_label_r     <= found_r ? spc_pkg::SLOT_BITS'(best_r) : '0;
      out_assigned_r  <= found_r;
      out_pass_done_r <= eop_r;
    end
  end

  // store write selection
  always_comb begin
    cm_we   = 1'b0;
    cm_addr = idx_r;
    cm_col  = cq_r;
    cm_pos  = pq_r;
    am_we   = 1'b0;
    am_addr = idx_r;
    am_csum = '0;
    am_psum = '0;
    am_cnt  = '0;
    if (load_ok) begin
      cm_we   = 1'b1;
      cm_addr = in_center_index[IW-1:0];
      cm_col  = {CW'(in_chan_b) << FRAC_BITS, CW'(in_chan_a) << FRAC_BITS,
                 CW'(in_chan_l) << FRAC_BITS};
      cm_pos  = {PW'(COORD_BITS'(in_pos_y)) << FRAC_BITS,
                 PW'(COORD_BITS'(in_pos_x)) << FRAC_BITS};
      am_we   = 1'b1;
      am_addr = in_center_index[IW-1:0];
    end else if (state_r == S_UPD_WR) begin
      am_we   = (cnt_q != spc_pkg::COUNT_MAX);
      am_csum = {csum_q[2*CSW +: CSW] + CSW'(col_r[2*CB +: CB]),
                 csum_q[CSW +: CSW]   + CSW'(col_r[CB +: CB]),
                 csum_q[0 +: CSW]     + CSW'(col_r[0 +: CB])};
      am_psum = {psum_q[PSW +: PSW] + PSW'(py_r),
                 psum_q[0 +: PSW]   + PSW'(px_r)};
      am_cnt  = cnt_q + 1'b1;
    end else if (state_r == S_FIN_WR) begin
      cm_we = fin_upd_r;
      am_we = 1'b1;
    end
  end

  // center store
  always_ff @(posedge clk) begin
    if (cm_we) begin
      ccol_mem[cm_addr] <= cm_col;
      cpos_mem[cm_addr] <= cm_pos;
    end
    ccol_q <= ccol_mem[idx_r];
    cpos_q <= cpos_mem[idx_r];
  end

  // sum and count store
  always_ff @(posedge clk) begin
    if (am_we) begin
      csum_mem[am_addr] <= am_csum;
      psum_mem[am_addr] <= am_psum;
      cnt_mem[am_addr]  <= am_cnt;
    end
    csum_q <= csum_mem[idx_r];
    psum_q <= psum_mem[idx_r];
    cnt_q  <= cnt_mem[idx_r];
  end

  assign out_valid     = out_valid_r;
  assign out_label     = out_label_r;
  assign out_assigned  = out_assigned_r;
  assign out_pass_done = out_pass_done_r;

  // a pixel transaction always leaves idle
  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_action == spc_pkg::ACT_PIXEL) |=> state_r != S_IDLE)
    else $error("pixel transaction did not start the walk");

  // a result appears only from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output state");

  // the divider finishes only while the sweep waits on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_FIN_DIV)
    else $error("divider finished outside the division state");

  // the winning center is live
  a_best_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && found_r |-> live_r[best_r])
    else $error("winning center is not live");

endmodule
